/* sv/tcb_pkg.sv */
// ----------------------------------------------------------------------------
// tcb_pkg
// Shared types and codes of the text cell buffer: commands, navigation keys,
// control characters, word layouts and the configuration write bundle.
// ----------------------------------------------------------------------------
package tcb_pkg;

    typedef logic [1:0]  t_cmd;
    typedef logic [15:0] t_cell;
    typedef logic [7:0]  t_rep;
    typedef logic [6:0]  t_caret_col;
    typedef logic [5:0]  t_caret_row;

    localparam t_cmd CMD_NAV  = 2'd0;
    localparam t_cmd CMD_TYPE = 2'd1;
    localparam t_cmd CMD_READ = 2'd2;

    localparam t_cell KEY_HOME  = 16'd0;
    localparam t_cell KEY_END   = 16'd1;
    localparam t_cell KEY_PGUP  = 16'd2;
    localparam t_cell KEY_PGDN  = 16'd3;
    localparam t_cell KEY_LEFT  = 16'd4;
    localparam t_cell KEY_RIGHT = 16'd5;
    localparam t_cell KEY_UP    = 16'd6;
    localparam t_cell KEY_DOWN  = 16'd7;
    localparam t_cell KEY_DEL   = 16'd8;

    localparam t_cell CH_SPACE = 16'h0020;
    localparam t_cell CH_BS    = 16'h0008;
    localparam t_cell CH_TAB   = 16'h0009;
    localparam t_cell CH_LF    = 16'h000A;
    localparam t_cell CH_CR    = 16'h000D;
    localparam t_cell CH_ESC   = 16'h001B;

    // tab stops sit on multiples of a power of two
    localparam int TAB_STOP = 8;

    // width used to compare read coordinates against the sizes in use
    localparam int CMP_W = 9;

    typedef enum logic {
        REG_COLUMNS = 1'b0,
        REG_ROWS    = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic       we;
        t_reg_idx   idx;
        logic [7:0] data;
    } t_cfg_wr;

    typedef struct packed {
        t_cmd       command;
        t_cell      code;
        t_rep       repeat_count;
        t_caret_col read_column;
        t_caret_row read_row;
    } t_item;

    typedef struct packed {
        t_caret_col caret_column;
        t_caret_row caret_row;
        t_cell      cell_value;
    } t_result;

endpackage

/* sv/tcb_if.sv */
// ----------------------------------------------------------------------------
// tcb_if
// Valid/ready channels of the text cell buffer: command words in, caret and
// cell words out.
// ----------------------------------------------------------------------------
interface tcb_in_if;
    import tcb_pkg::*;

    logic       valid;
    logic       ready;
    t_cmd       command;
    t_cell      code;
    t_rep       repeat_count;
    t_caret_col read_column;
    t_caret_row read_row;

    modport source(output valid, command, code, repeat_count, read_column, read_row,
                   input ready);
    modport sink(input valid, command, code, repeat_count, read_column, read_row,
                 output ready);
endinterface

interface tcb_out_if;
    import tcb_pkg::*;

    logic       valid;
    logic       ready;
    t_caret_col caret_column;
    t_caret_row caret_row;
    t_cell      cell_value;

    modport source(output valid, caret_column, caret_row, cell_value, input ready);
    modport sink(input valid, caret_column, caret_row, cell_value, output ready);
endinterface

/* sv/tcb_ram.sv */
// ----------------------------------------------------------------------------
// tcb_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module tcb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/tcb_seq.sv */
// ----------------------------------------------------------------------------
// tcb_seq
// Sequencer of the text cell buffer: holds sizes and caret, runs each
// command as read/modify/write steps on the cell RAM, clears the RAM.
// ----------------------------------------------------------------------------
module tcb_seq #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64,
    localparam int CW         = $clog2(MAX_COLUMNS),
    localparam int RW         = $clog2(MAX_ROWS),
    localparam int AW         = CW + RW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcb_pkg::t_cfg_wr  i_cfg,
    input  logic              i_item_valid,
    output logic              o_item_ready,
    input  tcb_pkg::t_item    i_item,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output tcb_pkg::t_result  o_res,
    output logic              o_ram_we,
    output logic [AW-1:0]     o_ram_waddr,
    output tcb_pkg::t_cell    o_ram_wdata,
    output logic [AW-1:0]     o_ram_raddr,
    input  tcb_pkg::t_cell    i_ram_rdata
);
    import tcb_pkg::*;

    localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int COLS_RST = (80 > MAX_COLUMNS) ? MAX_COLUMNS : 80;
    localparam int ROWS_RST = (25 > MAX_ROWS) ? MAX_ROWS : 25;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_EXEC    = 4'd2;
    localparam logic [3:0] S_DEL_RD  = 4'd3;
    localparam logic [3:0] S_DEL_WR  = 4'd4;
    localparam logic [3:0] S_DEL_END = 4'd5;
    localparam logic [3:0] S_TAB     = 4'd6;
    localparam logic [3:0] S_RD_WAIT = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]        r_state, n_state;
    logic              r_busy, n_busy;
    logic [CNT_W-1:0]  r_cols, n_cols;
    logic [RCNT_W-1:0] r_rows, n_rows;
    logic [CW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_row, n_row;
    t_cmd              r_cmd, n_cmd;
    t_cell             r_code, n_code;
    t_rep              r_rep, n_rep;
    t_caret_col        r_rcol, n_rcol;
    t_caret_row        r_rrow, n_rrow;
    logic [CW-1:0]     r_x, n_x;
    logic [AW-1:0]     r_clr, n_clr;
    t_cell             r_cell, n_cell;

    logic [CNT_W-1:0]  col_inc;
    logic              col_at_end;
    logic [RCNT_W-1:0] row_inc;
    logic [RW-1:0]     row_wrap;
    logic [CW-1:0]     adv_col;
    logic [RW-1:0]     adv_row;
    logic [CNT_W-1:0]  x_inc;
    logic              x_has_next;
    logic [CW-1:0]     cols_m1;
    logic [RW-1:0]     rows_m1;
    logic              in_range;
    logic [3:0]        finish_st;
    logic [CMP_W-1:0]  cfg_v;

    always_comb begin
        col_inc    = CNT_W'(r_col) + CNT_W'(1);
        col_at_end = col_inc >= r_cols;
        row_inc    = RCNT_W'(r_row) + RCNT_W'(1);
        row_wrap   = (row_inc >= r_rows) ? '0 : RW'(row_inc);
        adv_col    = col_at_end ? '0 : CW'(col_inc);
        adv_row    = col_at_end ? row_wrap : r_row;
        x_inc      = CNT_W'(r_x) + CNT_W'(1);
        x_has_next = x_inc < r_cols;
        cols_m1    = CW'(r_cols - CNT_W'(1));
        rows_m1    = RW'(r_rows - RCNT_W'(1));
        in_range   = (CMP_W'(r_rcol) < CMP_W'(r_cols)) &&
                     (CMP_W'(r_rrow) < CMP_W'(r_rows));
        finish_st  = (r_cmd == CMD_TYPE) ? S_EXEC : S_DONE;
    end

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        n_cols  = r_cols;
        n_rows  = r_rows;
        n_col   = r_col;
        n_row   = r_row;
        n_cmd   = r_cmd;
        n_code  = r_code;
        n_rep   = r_rep;
        n_rcol  = r_rcol;
        n_rrow  = r_rrow;
        n_x     = r_x;
        n_clr   = r_clr;
        n_cell  = r_cell;
        cfg_v   = '0;

        o_ram_we    = 1'b0;
        o_ram_waddr = {r_row, r_col};
        o_ram_wdata = CH_SPACE;
        o_ram_raddr = {r_row, CW'(x_inc)};

        unique case (r_state)
            S_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_clr;
                n_clr       = r_clr + AW'(1);
                if (r_clr == '1) begin
                    n_state = r_busy ? finish_st : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_item_valid) begin
                    n_busy  = 1'b1;
                    n_cmd   = i_item.command;
                    n_code  = i_item.code;
                    n_rep   = i_item.repeat_count;
                    n_rcol  = i_item.read_column;
                    n_rrow  = i_item.read_row;
                    n_cell  = '0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_cmd == CMD_NAV) begin
                    n_state = S_DONE;
                    unique case (r_code)
                        KEY_HOME:  n_col = '0;
                        KEY_END:   n_col = cols_m1;
                        KEY_PGUP:  n_row = '0;
                        KEY_PGDN:  n_row = rows_m1;
                        KEY_LEFT:  if (r_col != '0) n_col = r_col - CW'(1);
                        KEY_RIGHT: if (!col_at_end) n_col = CW'(col_inc);
                        KEY_UP:    if (r_row != '0) n_row = r_row - RW'(1);
                        KEY_DOWN:  if (row_inc < r_rows) n_row = RW'(row_inc);
                        KEY_DEL: begin
                            n_x     = r_col;
                            n_state = S_DEL_RD;
                        end
                        default: ;
                    endcase
                end else if (r_cmd == CMD_TYPE) begin
                    if (r_rep == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_rep = r_rep - t_rep'(1);
                        unique case (r_code)
                            CH_BS: begin
                                if (r_col != '0) begin
                                    n_col   = r_col - CW'(1);
                                    n_x     = r_col - CW'(1);
                                    n_state = S_DEL_RD;
                                end
                            end
                            CH_TAB: n_state = S_TAB;
                            CH_LF:  n_row = row_wrap;
                            CH_CR: begin
                                n_col = '0;
                                n_row = row_wrap;
                            end
                            CH_ESC: begin
                                n_col   = '0;
                                n_row   = '0;
                                n_clr   = '0;
                                n_state = S_CLEAR;
                            end
                            default: begin
                                o_ram_we    = 1'b1;
                                o_ram_wdata = r_code;
                                n_col       = adv_col;
                                n_row       = adv_row;
                            end
                        endcase
                    end
                end else if (r_cmd == CMD_READ) begin
                    o_ram_raddr = {RW'(r_rrow), CW'(r_rcol)};
                    n_state     = in_range ? S_RD_WAIT : S_DONE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DEL_RD: begin
                n_state = x_has_next ? S_DEL_WR : S_DEL_END;
            end
            S_DEL_WR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = {r_row, r_x};
                o_ram_wdata = i_ram_rdata;
                n_x         = CW'(x_inc);
                n_state     = S_DEL_RD;
            end
            S_DEL_END: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = {r_row, cols_m1};
                n_state     = finish_st;
            end
            S_TAB: begin
                o_ram_we = 1'b1;
                n_col    = adv_col;
                n_row    = adv_row;
                if ((adv_col & CW'(TAB_STOP - 1)) == '0) begin
                    n_state = finish_st;
                end
            end
            S_RD_WAIT: begin
                n_cell  = i_ram_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_busy  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg.we) begin
            if (i_cfg.idx == REG_COLUMNS) begin
                cfg_v = CMP_W'(i_cfg.data);
                if (cfg_v == '0) cfg_v = CMP_W'(1);
                if (cfg_v > CMP_W'(MAX_COLUMNS)) cfg_v = CMP_W'(MAX_COLUMNS);
                n_cols = CNT_W'(cfg_v);
            end else begin
                cfg_v = CMP_W'(i_cfg.data[6:0]);
                if (cfg_v == '0) cfg_v = CMP_W'(1);
                if (cfg_v > CMP_W'(MAX_ROWS)) cfg_v = CMP_W'(MAX_ROWS);
                n_rows = RCNT_W'(cfg_v);
            end
            n_col   = '0;
            n_row   = '0;
            n_clr   = '0;
            n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b0;
            r_cols  <= CNT_W'(COLS_RST);
            r_rows  <= RCNT_W'(ROWS_RST);
            r_col   <= '0;
            r_row   <= '0;
            r_rep   <= '0;
            r_x     <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_cols  <= n_cols;
            r_rows  <= n_rows;
            r_col   <= n_col;
            r_row   <= n_row;
            r_rep   <= n_rep;
            r_x     <= n_x;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_code <= n_code;
        r_rcol <= n_rcol;
        r_rrow <= n_rrow;
        r_cell <= n_cell;
    end

    assign o_item_ready       = (r_state == S_IDLE);
    assign o_res_valid        = (r_state == S_DONE);
    assign o_res.caret_column = t_caret_col'(r_col);
    assign o_res.caret_row    = t_caret_row'(r_row);
    assign o_res.cell_value   = r_cell;

endmodule

/* sv/text_cell_buffer_with_caret_top.sv */
// ----------------------------------------------------------------------------
// text_cell_buffer_with_caret_top
// Character cell text buffer with caret: cell RAM, command sequencer and
// output word register.
// ----------------------------------------------------------------------------
// One word in gives one word out. A navigation key, a read, a delete
// (which shifts the rest of the caret row left) and each repeat of a
// typed character (a tab writes spaces up to the next tab stop, a
// backspace steps back and shifts the row) run as steps of the sequencer
// on the single cell RAM, and then the result is handed over. Reset, a
// size write and an escape run a clearing pass over all
// 2**(clog2(MAX_ROWS) + clog2(MAX_COLUMNS)) cells (8192 by default), one
// cell a cycle, during which no input word is taken. A finished word waits
// in the output register while the next input word is taken.
module text_cell_buffer_with_caret_top #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcb_in_if.sink      i_in,
    tcb_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import tcb_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int AW = CW + RW;

    t_cfg_wr       w_cfg;
    t_item         w_item;
    logic          w_item_ready;
    t_result       w_res;
    logic          w_res_valid;
    logic          w_res_ready;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    t_cell         w_ram_wdata;
    logic [AW-1:0] w_ram_raddr;
    t_cell         w_ram_rdata;
    logic          w_load;

    logic          r_out_valid;
    t_result       r_out;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = t_reg_idx'(i_cfg_idx);
    assign w_cfg.data = i_cfg_data;

    assign w_item.command      = i_in.command;
    assign w_item.code         = i_in.code;
    assign w_item.repeat_count = i_in.repeat_count;
    assign w_item.read_column  = i_in.read_column;
    assign w_item.read_row     = i_in.read_row;
    assign i_in.ready          = w_item_ready;

    tcb_seq #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_item_valid(i_in.valid),
        .o_item_ready(w_item_ready),
        .i_item      (w_item),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    tcb_ram #(
        .WIDTH($bits(t_cell)),
        .DEPTH(2 ** AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_ram_waddr),
        .i_wdata(w_ram_wdata),
        .i_raddr(w_ram_raddr),
        .o_rdata(w_ram_rdata)
    );

    assign w_res_ready = !r_out_valid || o_out.ready;
    assign w_load      = w_res_valid && w_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.caret_column = r_out.caret_column;
    assign o_out.caret_row    = r_out.caret_row;
    assign o_out.cell_value   = r_out.cell_value;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && w_item_ready) |=> !w_item_ready)
        else $error("input taken twice in a row");

    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> !w_item_ready)
        else $error("input ready while a result is pending");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !w_item_ready)
        else $error("size write did not start clearing pass");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !w_item_ready)
        else $error("input ready right after reset");

endmodule

/* tb/sv/tb_text_cell_buffer_with_caret_top.sv */
// ----------------------------------------------------------------------------
// tb_text_cell_buffer_with_caret_top
// Self-checking bench for the text cell buffer: a directed table of keys,
// characters and reads, then random words over several screen sizes. Each
// word is run through a local screen/caret model when it is accepted, and
// every output word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_text_cell_buffer_with_caret_top;
    import tcb_pkg::*;

    localparam int NCOL = 128;
    localparam int NROW = 64;
    localparam int CLEAR_CYCLES = NCOL * NROW;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam t_cmd CMD_NONE = 2'd3;

    typedef struct {
        t_cmd       cmd;
        t_cell      code;
        t_rep       rep;
        t_caret_col rcol;
        t_caret_row rrow;
        bit         typed;
        t_caret_col ecol;
        t_caret_row erow;
        t_cell      ecell;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       cfg_we;
    t_reg_idx   cfg_idx;
    logic [7:0] cfg_data;

    tcb_in_if  in_if();
    tcb_out_if out_if();

    text_cell_buffer_with_caret_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // screen model
    t_cell       screen [NROW * NCOL];
    int unsigned car_col;
    int unsigned car_row;
    int unsigned scr_cols;
    int unsigned scr_rows;

    t_result caret_cell_q [$];
    int      errors;
    bit      idle_en;
    bit      hold_req;
    int      stall_left;

    function void screen_clear();
        for (int i = 0; i < NROW * NCOL; i++) screen[i] = CH_SPACE;
        car_col = 0;
        car_row = 0;
    endfunction

    function void screen_delete();
        for (int unsigned x = car_col; x + 1 < scr_cols; x++)
            screen[car_row * NCOL + x] = screen[car_row * NCOL + x + 1];
        screen[car_row * NCOL + scr_cols - 1] = CH_SPACE;
    endfunction

    function void caret_next_row();
        car_row++;
        if (car_row >= scr_rows) car_row = 0;
    endfunction

    function void screen_put(t_cell ch);
        screen[car_row * NCOL + car_col] = ch;
        car_col++;
        if (car_col >= scr_cols) begin
            car_col = 0;
            caret_next_row();
        end
    endfunction

    function void apply_key(t_cell key);
        case (key)
            KEY_HOME:  car_col = 0;
            KEY_END:   car_col = scr_cols - 1;
            KEY_PGUP:  car_row = 0;
            KEY_PGDN:  car_row = scr_rows - 1;
            KEY_LEFT:  if (car_col > 0) car_col--;
            KEY_RIGHT: if (car_col + 1 < scr_cols) car_col++;
            KEY_UP:    if (car_row > 0) car_row--;
            KEY_DOWN:  if (car_row + 1 < scr_rows) car_row++;
            KEY_DEL:   screen_delete();
            default: ;
        endcase
    endfunction

    function void apply_char(t_cell ch);
        case (ch)
            CH_BS: begin
                if (car_col > 0) begin
                    car_col--;
                    screen_delete();
                end
            end
            CH_TAB: begin
                do screen_put(CH_SPACE); while ((car_col % TAB_STOP) != 0);
            end
            CH_LF: caret_next_row();
            CH_CR: begin
                car_col = 0;
                caret_next_row();
            end
            CH_ESC: screen_clear();
            default: screen_put(ch);
        endcase
    endfunction

    function t_result terminal_step(t_item w);
        t_result r;
        t_cell   rd_val;
        rd_val = '0;
        case (w.command)
            CMD_NAV:  apply_key(w.code);
            CMD_TYPE: for (int i = 0; i < w.repeat_count; i++) apply_char(w.code);
            CMD_READ: begin
                if (w.read_column < scr_cols && w.read_row < scr_rows)
                    rd_val = screen[w.read_row * NCOL + w.read_column];
            end
            default: ;
        endcase
        r.caret_column = t_caret_col'(car_col);
        r.caret_row    = t_caret_row'(car_row);
        r.cell_value   = rd_val;
        return r;
    endfunction

    function void resize(t_reg_idx idx, logic [7:0] data);
        int unsigned v;
        v = (idx == REG_COLUMNS) ? data : (data & 8'h7F);
        if (v < 1) v = 1;
        if (idx == REG_COLUMNS) scr_cols = (v > NCOL) ? NCOL : v;
        else                    scr_rows = (v > NROW) ? NROW : v;
        screen_clear();
    endfunction

    function t_item random_word();
        t_item w;
        int unsigned pick;
        int unsigned sub;
        w.command      = CMD_NAV;
        w.code         = t_cell'($urandom_range(0, 16'hFFFF));
        w.repeat_count = t_rep'($urandom_range(0, 255));
        w.read_column  = t_caret_col'($urandom_range(0, NCOL - 1));
        w.read_row     = t_caret_row'($urandom_range(0, NROW - 1));
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            if ($urandom_range(0, 9) != 0) w.code = t_cell'($urandom_range(KEY_HOME, KEY_DEL));
        end else if (pick < 75) begin
            w.command = CMD_TYPE;
            sub = $urandom_range(0, 39);
            if (sub < 26)       w.code = t_cell'($urandom_range(CH_SPACE, 16'h7E));
            else if (sub < 29)  w.code = CH_BS;
            else if (sub < 32)  w.code = CH_TAB;
            else if (sub < 34)  w.code = CH_LF;
            else if (sub < 36)  w.code = CH_CR;
            else if (sub == 39) w.code = CH_ESC;
            sub = $urandom_range(0, 19);
            if (sub < 14)      w.repeat_count = t_rep'($urandom_range(1, 4));
            else if (sub < 18) w.repeat_count = t_rep'($urandom_range(0, 16));
            if (w.code == CH_ESC) w.repeat_count = t_rep'($urandom_range(0, 1));
        end else if (pick < 97) begin
            w.command = CMD_READ;
            if ($urandom_range(0, 3) != 0) begin
                w.read_column = t_caret_col'($urandom_range(0, scr_cols - 1));
                w.read_row    = t_caret_row'($urandom_range(0, scr_rows - 1));
            end
        end else begin
            w.command = CMD_NONE;
        end
        return w;
    endfunction

    task send_word(t_item w, bit typed, t_result typed_exp);
        t_result p;
        @(negedge i_clk);
        in_if.valid        = 1'b1;
        in_if.command      = w.command;
        in_if.code         = w.code;
        in_if.repeat_count = w.repeat_count;
        in_if.read_column  = w.read_column;
        in_if.read_row     = w.read_row;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        p = terminal_step(w);
        caret_cell_q.push_back(typed ? typed_exp : p);
    endtask

    task sender_gap();
        if (idle_en && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            in_if.valid = 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
    endtask

    task write_size(t_reg_idx idx, logic [7:0] data);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
        resize(idx, data);
    endtask

    // receiver: random bursts of back-pressure plus one long hold
    initial begin
        out_if.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) stall_left--;
            if (stall_left == 0) begin
                if (hold_req) begin
                    hold_req   = 1'b0;
                    stall_left = 300;
                end else if (idle_en && $urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, 4);
                end
            end
            out_if.ready = (stall_left == 0);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result e;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (caret_cell_q.size() == 0) begin
                $error("result word with no prediction pending");
                errors++;
            end else begin
                e = caret_cell_q.pop_front();
                if (out_if.caret_column !== e.caret_column) begin
                    $error("caret_column: expected %0d, got %0d",
                           e.caret_column, out_if.caret_column);
                    errors++;
                end
                if (out_if.caret_row !== e.caret_row) begin
                    $error("caret_row: expected %0d, got %0d", e.caret_row, out_if.caret_row);
                    errors++;
                end
                if (out_if.cell_value !== e.cell_value) begin
                    $error("cell_value: expected 0x%04h, got 0x%04h",
                           e.cell_value, out_if.cell_value);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    t_dir_row dir_tab [26] = '{
        '{CMD_READ, 16'h0000,  8'd0,   7'd0,   6'd0,  1'b1, 7'd0,  6'd0,  CH_SPACE},
        '{CMD_NAV,  KEY_END,   8'd0,   7'd0,   6'd0,  1'b1, 7'd79, 6'd0,  16'h0000},
        '{CMD_NAV,  KEY_PGDN,  8'd0,   7'd0,   6'd0,  1'b1, 7'd79, 6'd24, 16'h0000},
        '{CMD_NAV,  KEY_RIGHT, 8'd0,   7'd0,   6'd0,  1'b1, 7'd79, 6'd24, 16'h0000},
        '{CMD_NAV,  KEY_DOWN,  8'd0,   7'd0,   6'd0,  1'b1, 7'd79, 6'd24, 16'h0000},
        '{CMD_NAV,  KEY_HOME,  8'd0,   7'd0,   6'd0,  1'b1, 7'd0,  6'd24, 16'h0000},
        '{CMD_NAV,  KEY_LEFT,  8'd0,   7'd0,   6'd0,  1'b1, 7'd0,  6'd24, 16'h0000},
        '{CMD_NAV,  KEY_PGUP,  8'd0,   7'd0,   6'd0,  1'b1, 7'd0,  6'd0,  16'h0000},
        '{CMD_NAV,  KEY_UP,    8'd0,   7'd0,   6'd0,  1'b1, 7'd0,  6'd0,  16'h0000},
        '{CMD_TYPE, 16'h0041,  8'd3,   7'd0,   6'd0,  1'b1, 7'd3,  6'd0,  16'h0000},
        '{CMD_TYPE, 16'hFFFF,  8'd1,   7'd0,   6'd0,  1'b1, 7'd4,  6'd0,  16'h0000},
        '{CMD_READ, 16'h0000,  8'd0,   7'd3,   6'd0,  1'b1, 7'd4,  6'd0,  16'hFFFF},
        '{CMD_NAV,  16'hFFFF,  8'd0,   7'd0,   6'd0,  1'b1, 7'd4,  6'd0,  16'h0000},
        '{CMD_TYPE, 16'h005A,  8'd0,   7'd0,   6'd0,  1'b1, 7'd4,  6'd0,  16'h0000},
        '{CMD_NONE, 16'h1234,  8'd5,   7'd0,   6'd0,  1'b1, 7'd4,  6'd0,  16'h0000},
        '{CMD_TYPE, CH_BS,     8'd2,   7'd0,   6'd0,  1'b0, 7'd0,  6'd0,  16'h0000},
        '{CMD_NAV,  KEY_LEFT,  8'd0,   7'd0,   6'd0,  1'b0, 7'd0,  6'd0,  16'h0000},
        '{CMD_NAV,  KEY_DEL,   8'd0,   7'd0,   6'd0,  1'b0, 7'd0,  6'd0,  16'h0000},
        '{CMD_TYPE, CH_TAB,    8'd1,   7'd0,   6'd0,  1'b0, 7'd0,  6'd0,  16'h0000},
        '{CMD_TYPE, CH_LF,     8'd30,  7'd0,   6'd0,  1'b0, 7'd0,  6'd0,  16'h0000},
        '{CMD_TYPE, CH_CR,     8'd1,   7'd0,   6'd0,  1'b0, 7'd0,  6'd0,  16'h0000},
        '{CMD_READ, 16'h0000,  8'd0,   7'd127, 6'd63, 1'b0, 7'd0,  6'd0,  16'h0000},
        '{CMD_TYPE, 16'h0078,  8'd255, 7'd0,   6'd0,  1'b0, 7'd0,  6'd0,  16'h0000},
        '{CMD_TYPE, CH_ESC,    8'd1,   7'd0,   6'd0,  1'b1, 7'd0,  6'd0,  16'h0000},
        '{CMD_READ, 16'h0000,  8'd0,   7'd0,   6'd0,  1'b1, 7'd0,  6'd0,  CH_SPACE},
        '{CMD_TYPE, CH_BS,     8'd1,   7'd0,   6'd0,  1'b1, 7'd0,  6'd0,  16'h0000}
    };

    initial begin
        t_item      w;
        t_result    e;
        logic [7:0] plan_cols [6];
        logic [6:0] plan_rows [6];
        in_if.valid        = 1'b0;
        in_if.command      = CMD_NAV;
        in_if.code         = '0;
        in_if.repeat_count = '0;
        in_if.read_column  = '0;
        in_if.read_row     = '0;
        cfg_we   = 1'b0;
        cfg_idx  = REG_COLUMNS;
        cfg_data = '0;
        i_rst_n  = 1'b0;
        errors   = 0;
        idle_en  = 1'b1;
        hold_req = 1'b0;
        scr_cols = 80;
        scr_rows = 25;
        screen_clear();
        plan_cols = '{8'd1, 8'd128, 8'hFF, 8'd0, 8'd0, 8'd80};
        plan_rows = '{7'd1, 7'd64,  7'd0,  7'd127, 7'd0, 7'd25};
        plan_cols[4] = 8'($urandom_range(2, 127));
        plan_rows[4] = 7'($urandom_range(2, 63));

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[k]) begin
            w.command      = dir_tab[k].cmd;
            w.code         = dir_tab[k].code;
            w.repeat_count = dir_tab[k].rep;
            w.read_column  = dir_tab[k].rcol;
            w.read_row     = dir_tab[k].rrow;
            e.caret_column = dir_tab[k].ecol;
            e.caret_row    = dir_tab[k].erow;
            e.cell_value   = dir_tab[k].ecell;
            send_word(w, dir_tab[k].typed, e);
            sender_gap();
        end
        for (int n = 0; n < 104; n++) begin
            send_word(random_word(), 1'b0, e);
            sender_gap();
        end

        for (int ph = 0; ph < 6; ph++) begin
            @(negedge i_clk);
            in_if.valid = 1'b0;
            while (caret_cell_q.size() != 0) @(posedge i_clk);
            repeat (8) @(posedge i_clk);
            write_size(REG_COLUMNS, plan_cols[ph]);
            repeat (CLEAR_CYCLES + 16) @(posedge i_clk);
            write_size(REG_ROWS, {1'b0, plan_rows[ph]});
            if (ph == 5) idle_en = 1'b0;
            for (int n = 0; n < 130; n++) begin
                if (ph == 0 && n == 10) hold_req = 1'b1;
                send_word(random_word(), 1'b0, e);
                sender_gap();
            end
        end

        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (caret_cell_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && caret_cell_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
